>>> rtl/core/interrupt_priority_level_evaluator_macros.svh
// ----------------------------------------------------------------------------
// interrupt priority level evaluator: assertion macros
// Concurrent assertion shorthands clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_PRIORITY_LEVEL_EVALUATOR_MACROS_SVH
`define INTERRUPT_PRIORITY_LEVEL_EVALUATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define IPLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IPLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/iple_pkg.sv
// ----------------------------------------------------------------------------
// iple_pkg
// Shared types, codes and constants of the interrupt priority level evaluator.
// ----------------------------------------------------------------------------
package iple_pkg;

    // field widths
    localparam int LEVEL_W   = 5;
    localparam int BUS_W     = 4;
    localparam int BUS_IDX_W = 2;
    localparam int SOFT_W    = 16;
    localparam int POST_W    = 5;
    localparam int CFG_IDX_W = 3;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // default sizes of the bus and software level ranges
    localparam int BUS_LEVELS_DEF  = 4;
    localparam int SOFT_LEVELS_DEF = 16;

    // pending flag positions
    localparam int FLAG_TIMER   = 0;
    localparam int FLAG_CON_IN  = 1;
    localparam int FLAG_CON_OUT = 2;
    localparam int FLAG_STOR_IN = 3;
    localparam int FLAG_STOR_OUT = 4;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [POST_W-1:0]  flags_t;

    typedef enum logic [0:0] {
        OP_EVAL = 1'b0,
        OP_ACK  = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        SRC_NONE     = 4'd0,
        SRC_HALT     = 4'd1,
        SRC_TIMER    = 4'd2,
        SRC_BUS      = 4'd3,
        SRC_CON_IN   = 4'd4,
        SRC_CON_OUT  = 4'd5,
        SRC_STOR_IN  = 4'd6,
        SRC_STOR_OUT = 4'd7,
        SRC_SOFT     = 4'd8
    } src_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALT_LEVEL    = 3'd0,
        CFG_CLOCK_LEVEL   = 3'd1,
        CFG_BUS_LOW_LEVEL = 3'd2,
        CFG_BUS_HIGH_LEVEL = 3'd3,
        CFG_CONSOLE_LEVEL = 3'd4,
        CFG_STORAGE_LEVEL = 3'd5
    } cfg_idx_t;

    // register reset values
    localparam level_t HALT_LEVEL_RST     = 5'd31;
    localparam level_t CLOCK_LEVEL_RST    = 5'd24;
    localparam level_t BUS_LOW_LEVEL_RST  = 5'd20;
    localparam level_t BUS_HIGH_LEVEL_RST = 5'd23;
    localparam level_t CONSOLE_LEVEL_RST  = 5'd20;
    localparam level_t STORAGE_LEVEL_RST  = 5'd20;

    typedef struct packed {
        level_t halt_level;
        level_t clock_level;
        level_t bus_low_level;
        level_t bus_high_level;
        level_t console_level;
        level_t storage_level;
    } cfg_regs_t;

    typedef struct packed {
        op_t                 op;
        level_t              current_ipl;
        logic                halt_pin;
        logic [BUS_W-1:0]    bus_requests;
        logic [SOFT_W-1:0]   soft_requests;
        flags_t              post_requests;
        level_t              ack_level;
    } item_t;

    typedef struct packed {
        level_t           grant_level;
        src_t             source;
        logic [BUS_W-1:0] bus_index;
        logic             bad_level;
    } result_t;

endpackage

>>> rtl/core/iple_cfg.sv
// ----------------------------------------------------------------------------
// iple_cfg
// Level configuration registers, written one at a time by index.
// ----------------------------------------------------------------------------
module iple_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [iple_pkg::CFG_IDX_W-1:0]      wr_index,
    input  iple_pkg::level_t                    wr_data,
    output iple_pkg::cfg_regs_t                 cfg
);

    iple_pkg::cfg_regs_t cfg_reg;
    iple_pkg::cfg_regs_t cfg_next;

    // register decode, indexes past the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (iple_pkg::cfg_idx_t'(wr_index))
                iple_pkg::CFG_HALT_LEVEL:     cfg_next.halt_level     = wr_data;
                iple_pkg::CFG_CLOCK_LEVEL:    cfg_next.clock_level    = wr_data;
                iple_pkg::CFG_BUS_LOW_LEVEL:  cfg_next.bus_low_level  = wr_data;
                iple_pkg::CFG_BUS_HIGH_LEVEL: cfg_next.bus_high_level = wr_data;
                iple_pkg::CFG_CONSOLE_LEVEL:  cfg_next.console_level  = wr_data;
                iple_pkg::CFG_STORAGE_LEVEL:  cfg_next.storage_level  = wr_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.halt_level     <= iple_pkg::HALT_LEVEL_RST;
            cfg_reg.clock_level    <= iple_pkg::CLOCK_LEVEL_RST;
            cfg_reg.bus_low_level  <= iple_pkg::BUS_LOW_LEVEL_RST;
            cfg_reg.bus_high_level <= iple_pkg::BUS_HIGH_LEVEL_RST;
            cfg_reg.console_level  <= iple_pkg::CONSOLE_LEVEL_RST;
            cfg_reg.storage_level  <= iple_pkg::STORAGE_LEVEL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/iple_eval.sv
// ----------------------------------------------------------------------------
// iple_eval
// Priority evaluation and acknowledge decode for one item, combinational.
// ----------------------------------------------------------------------------
module iple_eval #(
    parameter int BUS_LEVELS  = iple_pkg::BUS_LEVELS_DEF,
    parameter int SOFT_LEVELS = iple_pkg::SOFT_LEVELS_DEF
) (
    input  iple_pkg::item_t      item,
    input  iple_pkg::cfg_regs_t  cfg,
    input  iple_pkg::flags_t     pending,
    output iple_pkg::result_t    res,
    output iple_pkg::flags_t     pending_next
);

    // bus lanes that can request at all
    localparam int BUS_LANES = (BUS_LEVELS < iple_pkg::BUS_W) ? BUS_LEVELS : iple_pkg::BUS_W;
    localparam int SOFT_USED = (SOFT_LEVELS < iple_pkg::SOFT_W) ? SOFT_LEVELS : iple_pkg::SOFT_W;

    iple_pkg::flags_t            flags;
    logic [iple_pkg::BUS_W-1:0]  bus_hit;
    logic                        bus_any;
    logic [iple_pkg::BUS_IDX_W-1:0] bus_sel;
    logic                        bus_stop;
    logic                        soft_any;
    iple_pkg::level_t            soft_lvl;
    iple_pkg::level_t            ack_idx;
    logic                        ack_bus;
    logic                        con_pend;
    logic                        stor_pend;

    // posted requests join the pending flags first
    assign flags = pending | item.post_requests;
    assign con_pend  = flags[iple_pkg::FLAG_CON_IN] | flags[iple_pkg::FLAG_CON_OUT];
    assign stor_pend = flags[iple_pkg::FLAG_STOR_IN] | flags[iple_pkg::FLAG_STOR_OUT];

    // one compare per bus lane, in range and above the current ipl
    always_comb
    begin
        logic [iple_pkg::LEVEL_W:0] lane_lvl;
        for (int idx = 0; idx < iple_pkg::BUS_W; idx++)
        begin
            lane_lvl = {1'b0, cfg.bus_low_level} + (iple_pkg::LEVEL_W+1)'(idx);
            bus_hit[idx] = (idx < BUS_LANES) && item.bus_requests[idx]
                && (lane_lvl <= {1'b0, cfg.bus_high_level})
                && (lane_lvl > {1'b0, item.current_ipl});
        end
    end

    // highest bus lane wins
    always_comb
    begin
        bus_any = 1'b0;
        bus_sel = '0;
        for (int idx = 0; idx < iple_pkg::BUS_W; idx++)
        begin
            if (bus_hit[idx])
            begin
                bus_any = 1'b1;
                bus_sel = iple_pkg::BUS_IDX_W'(idx);
            end
        end
    end

    // downward bus scan meets a level at or below ipl and ends the search
    assign bus_stop = (cfg.bus_high_level >= cfg.bus_low_level)
        && (cfg.bus_low_level <= item.current_ipl);

    // software levels above ipl, highest first
    always_comb
    begin
        soft_any = 1'b0;
        soft_lvl = '0;
        for (int i = 0; i < iple_pkg::SOFT_W; i++)
        begin
            if ((i < SOFT_USED) && item.soft_requests[i]
                && (iple_pkg::LEVEL_W'(i) > item.current_ipl))
            begin
                soft_any = 1'b1;
                soft_lvl = iple_pkg::LEVEL_W'(i);
            end
        end
    end

    // acknowledge at a requesting bus level
    assign ack_idx = item.ack_level - cfg.bus_low_level;
    assign ack_bus = (item.ack_level >= cfg.bus_low_level) && (ack_idx < BUS_LANES)
        && item.bus_requests[ack_idx[iple_pkg::BUS_IDX_W-1:0]];

    // result selection and flag clearing
    always_comb
    begin
        res          = '0;
        res.source   = iple_pkg::SRC_NONE;
        pending_next = flags;
        if (item.op == iple_pkg::OP_EVAL)
        begin
            if (item.halt_pin)
            begin
                res.grant_level = cfg.halt_level;
                res.source      = iple_pkg::SRC_HALT;
            end
            else if ((item.current_ipl < cfg.clock_level) && flags[iple_pkg::FLAG_TIMER])
            begin
                res.grant_level = cfg.clock_level;
                res.source      = iple_pkg::SRC_TIMER;
            end
            else if (bus_any)
            begin
                res.grant_level = cfg.bus_low_level + iple_pkg::LEVEL_W'(bus_sel);
                res.source      = iple_pkg::SRC_BUS;
                res.bus_index   = iple_pkg::BUS_W'(bus_sel);
            end
            else if (bus_stop)
            begin
                res.source = iple_pkg::SRC_NONE;
            end
            else if ((item.current_ipl < cfg.console_level) && con_pend)
            begin
                res.grant_level = cfg.console_level;
                res.source      = flags[iple_pkg::FLAG_CON_IN] ? iple_pkg::SRC_CON_IN
                                                               : iple_pkg::SRC_CON_OUT;
            end
            else if ((item.current_ipl < cfg.storage_level) && stor_pend)
            begin
                res.grant_level = cfg.storage_level;
                res.source      = flags[iple_pkg::FLAG_STOR_IN] ? iple_pkg::SRC_STOR_IN
                                                                : iple_pkg::SRC_STOR_OUT;
            end
            else if (soft_any)
            begin
                res.grant_level = soft_lvl;
                res.source      = iple_pkg::SRC_SOFT;
            end
        end
        else
        begin
            res.grant_level = item.ack_level;
            if (item.ack_level == cfg.clock_level)
            begin
                pending_next[iple_pkg::FLAG_TIMER] = 1'b0;
                res.source = iple_pkg::SRC_TIMER;
            end
            else if (item.ack_level > cfg.bus_high_level)
            begin
                res.bad_level = 1'b1;
            end
            else if (ack_bus)
            begin
                res.source    = iple_pkg::SRC_BUS;
                res.bus_index = ack_idx[iple_pkg::BUS_W-1:0];
            end
            else if ((item.ack_level == cfg.console_level) && con_pend)
            begin
                if (flags[iple_pkg::FLAG_CON_IN])
                begin
                    pending_next[iple_pkg::FLAG_CON_IN] = 1'b0;
                    res.source = iple_pkg::SRC_CON_IN;
                end
                else
                begin
                    pending_next[iple_pkg::FLAG_CON_OUT] = 1'b0;
                    res.source = iple_pkg::SRC_CON_OUT;
                end
            end
            else if ((item.ack_level == cfg.storage_level) && stor_pend)
            begin
                if (flags[iple_pkg::FLAG_STOR_IN])
                begin
                    pending_next[iple_pkg::FLAG_STOR_IN] = 1'b0;
                    res.source = iple_pkg::SRC_STOR_IN;
                end
                else
                begin
                    pending_next[iple_pkg::FLAG_STOR_OUT] = 1'b0;
                    res.source = iple_pkg::SRC_STOR_OUT;
                end
            end
        end
    end

endmodule

>>> rtl/core/interrupt_priority_level_evaluator.sv
// ----------------------------------------------------------------------------
// interrupt_priority_level_evaluator
// Interrupt priority arbiter with pending device flags and level registers.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            contents
//  s_*       in   s_tvalid/s_tready    request beat: op in tuser, fields in tdata
//  m_*       out  m_tvalid/m_tready    result beat: level, source, bus index, error
//  cfg_*     in   cfg_valid/cfg_ready  level register write by index
//
//  one beat per cycle sustained while m_tready is high; a beat is held in the
//  input register and its result is loaded into the result register as it
//  leaves, which raises m_tvalid. the pending flags update as a beat leaves
//  the input register. a stalled output holds the result while one more beat
//  is taken into the input register.
//  cfg_ready is always high; reset is immediate.
// ----------------------------------------------------------------------------
module interrupt_priority_level_evaluator #(
    parameter int BUS_LEVELS  = iple_pkg::BUS_LEVELS_DEF,
    parameter int SOFT_LEVELS = iple_pkg::SOFT_LEVELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // current_ipl, halt_pin, bus_requests, soft_requests, post_requests, ack_level
    input  logic [iple_pkg::S_TDATA_W-1:0]      s_tdata,
    // op
    input  logic [0:0]                          s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // grant_level, source, bus_index, bad_level
    output logic [iple_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iple_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iple_pkg::LEVEL_W-1:0]        cfg_data
);

    iple_pkg::cfg_regs_t  cfg;
    iple_pkg::item_t      in_item;
    iple_pkg::item_t      item_reg;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    iple_pkg::result_t    res_reg;
    iple_pkg::result_t    res_comb;
    iple_pkg::flags_t     pending_reg;
    iple_pkg::flags_t     pending_comb;
    logic                 advance;
    logic                 s_accept;

    // configuration registers
    assign cfg_ready = 1'b1;

    iple_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // unpack the request beat
    assign in_item.op            = iple_pkg::op_t'(s_tuser[0]);
    assign in_item.current_ipl   = s_tdata[4:0];
    assign in_item.halt_pin      = s_tdata[5];
    assign in_item.bus_requests  = s_tdata[9:6];
    assign in_item.soft_requests = s_tdata[25:10];
    assign in_item.post_requests = s_tdata[30:26];
    assign in_item.ack_level     = s_tdata[35:31];

    // pipeline flow control
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign s1_valid_next  = s_accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    // evaluation between the two registers
    iple_eval #(
        .BUS_LEVELS  (BUS_LEVELS),
        .SOFT_LEVELS (SOFT_LEVELS)
    ) u_eval (
        .item         (item_reg),
        .cfg          (cfg),
        .pending      (pending_reg),
        .res          (res_comb),
        .pending_next (pending_comb)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_valid_reg && advance)
            begin
                pending_reg <= pending_comb;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg <= in_item;
        end
        if (s1_valid_reg && advance)
        begin
            res_reg <= res_comb;
        end
    end

    // pack the result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg.bad_level, res_reg.bus_index,
                       res_reg.source, res_reg.grant_level};

    // checks
    `include "interrupt_priority_level_evaluator_macros.svh"

    `IPLE_ASSERT_SAME(a_bad_without_source,
        m_tvalid && res_reg.bad_level,
        res_reg.source == iple_pkg::SRC_NONE && res_reg.bus_index == '0,
        "error result carries a source")
    `IPLE_ASSERT_SAME(a_bus_index_only_bus,
        m_tvalid && res_reg.source != iple_pkg::SRC_BUS,
        res_reg.bus_index == '0,
        "bus index set for a non-bus source")
    `IPLE_ASSERT_NEXT(a_timer_ack_clears,
        s1_valid_reg && advance && item_reg.op == iple_pkg::OP_ACK
            && item_reg.ack_level == cfg.clock_level,
        !pending_reg[iple_pkg::FLAG_TIMER],
        "timer flag survives an acknowledge at clock level")
    `IPLE_ASSERT_SAME(a_stall_only_when_full,
        !s_tready,
        s1_valid_reg && out_valid_reg && !m_tready,
        "input stalled with room in the pipeline")

endmodule

>>> tb/tb_interrupt_priority_level_evaluator.sv
// ----------------------------------------------------------------------------
// tb_interrupt_priority_level_evaluator
// Self-checking bench for the interrupt priority arbiter. A directed table
// runs at the reset levels, then each level setting gets a few fixed beats
// and a run of random beats. Each accepted request is scored against the
// table or a local grant model. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module tb_interrupt_priority_level_evaluator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_BUS        = iple_pkg::BUS_LEVELS_DEF;
    localparam int N_SOFT       = iple_pkg::SOFT_LEVELS_DEF;
    localparam int ITEMS_PER_CFG = 78;

    typedef struct {
        iple_pkg::item_t   it;
        bit                typed;
        iple_pkg::result_t res;
    } stim_row_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [iple_pkg::S_TDATA_W-1:0]      s_tdata = '0;
    logic [0:0]                          s_tuser = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [iple_pkg::M_TDATA_W-1:0]      m_tdata;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [iple_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [iple_pkg::LEVEL_W-1:0]        cfg_data = '0;

    // model state
    iple_pkg::cfg_regs_t lvl_cfg;
    iple_pkg::flags_t    pend_flags;
    iple_pkg::level_t    last_grant;

    iple_pkg::result_t   grant_q[$];
    stim_row_t           dir_rows[$];
    iple_pkg::cfg_regs_t settings[$];

    int err_cnt     = 0;
    int items_sent  = 0;
    int results_seen = 0;
    int cfg_writes  = 0;
    int burst_left  = 0;
    int rx_cyc      = 0;

    interrupt_priority_level_evaluator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // bus request bit for an index, out-of-range indexes never request
    function automatic bit bus_hit(input logic [iple_pkg::BUS_W-1:0] bus, input int idx);
        if (idx < 0 || idx >= N_BUS || idx >= iple_pkg::BUS_W)
            return 1'b0;
        return bus[idx];
    endfunction

    // grant and acknowledge behaviour, updates the pending flags
    function automatic iple_pkg::result_t predict_grant(input iple_pkg::item_t it);
        iple_pkg::result_t              r;
        logic [iple_pkg::BUS_W-1:0]     bus;
        logic [iple_pkg::SOFT_W-1:0]    soft_bits;
        int                             i;
        int                             hi;
        int                             lo;
        int                             ipl;
        int                             lvl;
        bit                             done;
        r = '0;
        r.source = iple_pkg::SRC_NONE;
        done = 1'b0;
        hi = lvl_cfg.bus_high_level;
        lo = lvl_cfg.bus_low_level;
        ipl = it.current_ipl;
        bus = it.bus_requests & iple_pkg::BUS_W'((1 << N_BUS) - 1);
        soft_bits = it.soft_requests & iple_pkg::SOFT_W'((1 << N_SOFT) - 1);
        pend_flags = pend_flags | it.post_requests;

        if (it.op == iple_pkg::OP_EVAL)
        begin
            if (it.halt_pin)
            begin
                r.grant_level = lvl_cfg.halt_level;
                r.source = iple_pkg::SRC_HALT;
                done = 1'b1;
            end
            else if (ipl < int'(lvl_cfg.clock_level) && pend_flags[iple_pkg::FLAG_TIMER])
            begin
                r.grant_level = lvl_cfg.clock_level;
                r.source = iple_pkg::SRC_TIMER;
                done = 1'b1;
            end
            // bus scan from the top, a level not above the ipl ends everything
            if (!done && hi >= lo)
            begin
                for (i = hi; i >= lo && !done; i--)
                begin
                    if (i <= ipl)
                        done = 1'b1;
                    else if (bus_hit(bus, i - lo))
                    begin
                        r.grant_level = iple_pkg::level_t'(i);
                        r.source = iple_pkg::SRC_BUS;
                        r.bus_index = iple_pkg::BUS_W'(i - lo);
                        done = 1'b1;
                    end
                end
            end
            if (!done && ipl < int'(lvl_cfg.console_level)
                && (pend_flags[iple_pkg::FLAG_CON_IN] || pend_flags[iple_pkg::FLAG_CON_OUT]))
            begin
                r.grant_level = lvl_cfg.console_level;
                r.source = pend_flags[iple_pkg::FLAG_CON_IN] ? iple_pkg::SRC_CON_IN
                                                             : iple_pkg::SRC_CON_OUT;
                done = 1'b1;
            end
            if (!done && ipl < int'(lvl_cfg.storage_level)
                && (pend_flags[iple_pkg::FLAG_STOR_IN]
                    || pend_flags[iple_pkg::FLAG_STOR_OUT]))
            begin
                r.grant_level = lvl_cfg.storage_level;
                r.source = pend_flags[iple_pkg::FLAG_STOR_IN] ? iple_pkg::SRC_STOR_IN
                                                              : iple_pkg::SRC_STOR_OUT;
                done = 1'b1;
            end
            // software levels above the ipl
            if (!done && ipl < N_SOFT - 1)
            begin
                for (i = N_SOFT - 1; i > ipl && !done; i--)
                begin
                    if (soft_bits[i])
                    begin
                        r.grant_level = iple_pkg::level_t'(i);
                        r.source = iple_pkg::SRC_SOFT;
                        done = 1'b1;
                    end
                end
            end
        end
        else
        begin
            lvl = it.ack_level;
            r.grant_level = it.ack_level;
            if (lvl == int'(lvl_cfg.clock_level))
            begin
                pend_flags[iple_pkg::FLAG_TIMER] = 1'b0;
                r.source = iple_pkg::SRC_TIMER;
                done = 1'b1;
            end
            else if (lvl > hi)
            begin
                r.bad_level = 1'b1;
                done = 1'b1;
            end
            else if (lvl >= lo && bus_hit(bus, lvl - lo))
            begin
                r.source = iple_pkg::SRC_BUS;
                r.bus_index = iple_pkg::BUS_W'(lvl - lo);
                done = 1'b1;
            end
            if (!done && lvl == int'(lvl_cfg.console_level))
            begin
                if (pend_flags[iple_pkg::FLAG_CON_IN])
                begin
                    pend_flags[iple_pkg::FLAG_CON_IN] = 1'b0;
                    r.source = iple_pkg::SRC_CON_IN;
                    done = 1'b1;
                end
                else if (pend_flags[iple_pkg::FLAG_CON_OUT])
                begin
                    pend_flags[iple_pkg::FLAG_CON_OUT] = 1'b0;
                    r.source = iple_pkg::SRC_CON_OUT;
                    done = 1'b1;
                end
            end
            if (!done && lvl == int'(lvl_cfg.storage_level))
            begin
                if (pend_flags[iple_pkg::FLAG_STOR_IN])
                begin
                    pend_flags[iple_pkg::FLAG_STOR_IN] = 1'b0;
                    r.source = iple_pkg::SRC_STOR_IN;
                end
                else if (pend_flags[iple_pkg::FLAG_STOR_OUT])
                begin
                    pend_flags[iple_pkg::FLAG_STOR_OUT] = 1'b0;
                    r.source = iple_pkg::SRC_STOR_OUT;
                end
            end
        end
        return r;
    endfunction

    function automatic stim_row_t row(input iple_pkg::op_t op, input int ipl, input bit halt,
                                      input int bus, input int soft_req, input int post,
                                      input int ack, input bit typed, input int grant,
                                      input iple_pkg::src_t src, input int bidx,
                                      input bit bad);
        stim_row_t s;
        s.it.op            = op;
        s.it.current_ipl   = iple_pkg::level_t'(ipl);
        s.it.halt_pin      = halt;
        s.it.bus_requests  = iple_pkg::BUS_W'(bus);
        s.it.soft_requests = iple_pkg::SOFT_W'(soft_req);
        s.it.post_requests = iple_pkg::flags_t'(post);
        s.it.ack_level     = iple_pkg::level_t'(ack);
        s.typed            = typed;
        s.res.grant_level  = iple_pkg::level_t'(grant);
        s.res.source       = src;
        s.res.bus_index    = iple_pkg::BUS_W'(bidx);
        s.res.bad_level    = bad;
        return s;
    endfunction

    function automatic iple_pkg::cfg_regs_t mk_cfg(input int h, input int c, input int lo,
                                                   input int hi, input int con,
                                                   input int st);
        iple_pkg::cfg_regs_t k;
        k.halt_level     = iple_pkg::level_t'(h);
        k.clock_level    = iple_pkg::level_t'(c);
        k.bus_low_level  = iple_pkg::level_t'(lo);
        k.bus_high_level = iple_pkg::level_t'(hi);
        k.console_level  = iple_pkg::level_t'(con);
        k.storage_level  = iple_pkg::level_t'(st);
        return k;
    endfunction

    // level near one of the configured ones, or anywhere
    function automatic iple_pkg::level_t near_level();
        int base;
        int v;
        case ($urandom_range(0, 6))
            0: base = lvl_cfg.clock_level;
            1: base = lvl_cfg.bus_low_level;
            2: base = lvl_cfg.bus_high_level;
            3: base = lvl_cfg.console_level;
            4: base = lvl_cfg.storage_level;
            5: base = lvl_cfg.bus_low_level + $urandom_range(0, 3);
            default: base = $urandom_range(0, 31);
        endcase
        v = base + $urandom_range(0, 2) - 1;
        if (v < 0)
            v = 0;
        if (v > 31)
            v = 31;
        return iple_pkg::level_t'(v);
    endfunction

    // mostly post/evaluate/acknowledge flows with random content
    function automatic iple_pkg::item_t gen_item();
        iple_pkg::item_t it;
        int              k;
        it.op = ($urandom_range(0, 1) == 0) ? iple_pkg::OP_EVAL : iple_pkg::OP_ACK;
        it.current_ipl = ($urandom_range(0, 1) == 0)
                       ? iple_pkg::level_t'($urandom_range(0, 31)) : near_level();
        it.halt_pin = ($urandom_range(0, 11) == 0);
        it.bus_requests = ($urandom_range(0, 9) < 3) ? '0 : iple_pkg::BUS_W'($urandom);
        k = $urandom_range(0, 3);
        if (k < 2)
            it.soft_requests = iple_pkg::SOFT_W'($urandom);
        else if (k == 2)
            it.soft_requests = iple_pkg::SOFT_W'(1 << $urandom_range(0, iple_pkg::SOFT_W - 1));
        else
            it.soft_requests = '0;
        it.post_requests = ($urandom_range(0, 9) < 6) ? '0 : iple_pkg::flags_t'($urandom);
        k = $urandom_range(0, 9);
        if (k < 4)
            it.ack_level = last_grant;
        else if (k < 8)
            it.ack_level = near_level();
        else
            it.ack_level = iple_pkg::level_t'($urandom_range(0, 31));
        return it;
    endfunction

    // one request beat, its expected result queued at acceptance
    task automatic send_item(input iple_pkg::item_t it, input bit typed,
                             input iple_pkg::result_t tv);
        iple_pkg::result_t pred;
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {4'b0, it.ack_level, it.post_requests, it.soft_requests,
                     it.bus_requests, it.halt_pin, it.current_ipl};
        do
            @(posedge clk);
        while (!s_tready);
        pred = predict_grant(it);
        last_grant = pred.grant_level;
        grant_q.push_back(typed ? tv : pred);
        items_sent++;
    endtask

    // sender bursts and gaps
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic run_rows();
        stim_row_t s;
        while (dir_rows.size() != 0)
        begin
            s = dir_rows.pop_front();
            send_item(s.it, s.typed, s.res);
            pace_sender();
        end
    endtask

    // stop sending and let every outstanding result arrive
    task automatic drain();
        s_tvalid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input iple_pkg::cfg_idx_t idx, input iple_pkg::level_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            iple_pkg::CFG_HALT_LEVEL:     lvl_cfg.halt_level     = val;
            iple_pkg::CFG_CLOCK_LEVEL:    lvl_cfg.clock_level    = val;
            iple_pkg::CFG_BUS_LOW_LEVEL:  lvl_cfg.bus_low_level  = val;
            iple_pkg::CFG_BUS_HIGH_LEVEL: lvl_cfg.bus_high_level = val;
            iple_pkg::CFG_CONSOLE_LEVEL:  lvl_cfg.console_level  = val;
            iple_pkg::CFG_STORAGE_LEVEL:  lvl_cfg.storage_level  = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic apply_cfg(input iple_pkg::cfg_regs_t k);
        cfg_write(iple_pkg::CFG_HALT_LEVEL,     k.halt_level);
        cfg_write(iple_pkg::CFG_CLOCK_LEVEL,    k.clock_level);
        cfg_write(iple_pkg::CFG_BUS_LOW_LEVEL,  k.bus_low_level);
        cfg_write(iple_pkg::CFG_BUS_HIGH_LEVEL, k.bus_high_level);
        cfg_write(iple_pkg::CFG_CONSOLE_LEVEL,  k.console_level);
        cfg_write(iple_pkg::CFG_STORAGE_LEVEL,  k.storage_level);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // result scoring and receiver stall pattern
    always @(posedge clk)
    begin
        iple_pkg::result_t got;
        iple_pkg::result_t exp_r;
        int                mode;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.grant_level = m_tdata[4:0];
            got.source      = iple_pkg::src_t'(m_tdata[8:5]);
            got.bus_index   = m_tdata[12:9];
            got.bad_level   = m_tdata[13];
            results_seen++;
            if (grant_q.size() == 0)
            begin
                $error("result beat with nothing expected: %h", m_tdata);
                err_cnt++;
            end
            else
            begin
                exp_r = grant_q.pop_front();
                if (got.grant_level !== exp_r.grant_level)
                begin
                    $error("grant_level mismatch: expected %0d, got %0d",
                           exp_r.grant_level, got.grant_level);
                    err_cnt++;
                end
                if (got.source !== exp_r.source)
                begin
                    $error("source mismatch: expected %0d, got %0d",
                           exp_r.source, got.source);
                    err_cnt++;
                end
                if (got.bus_index !== exp_r.bus_index)
                begin
                    $error("bus_index mismatch: expected %0d, got %0d",
                           exp_r.bus_index, got.bus_index);
                    err_cnt++;
                end
                if (got.bad_level !== exp_r.bad_level)
                begin
                    $error("bad_level mismatch: expected %0d, got %0d",
                           exp_r.bad_level, got.bad_level);
                    err_cnt++;
                end
            end
        end
        rx_cyc++;
        mode = (rx_cyc / 97) % 4;
        case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (rx_cyc % 4 != 0);
            default: m_tready <= (rx_cyc % 8 == 7);
        endcase
    end

    // main sequence
    initial
    begin
        int                  n;
        int                  p;
        iple_pkg::cfg_regs_t k;
        iple_pkg::item_t     it;
        iple_pkg::result_t   none_r;

        none_r = '0;
        lvl_cfg = mk_cfg(iple_pkg::HALT_LEVEL_RST, iple_pkg::CLOCK_LEVEL_RST,
                         iple_pkg::BUS_LOW_LEVEL_RST, iple_pkg::BUS_HIGH_LEVEL_RST,
                         iple_pkg::CONSOLE_LEVEL_RST, iple_pkg::STORAGE_LEVEL_RST);
        pend_flags = '0;
        last_grant = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset levels
        // nothing pending, idle processor
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 0, 0, 0, 0, 0, 0,
                               1, 0, iple_pkg::SRC_NONE, 0, 0));
        // halt wins even at the top ipl
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 31, 1, 15, 16'hFFFF, 0, 31,
                               1, 31, iple_pkg::SRC_HALT, 0, 0));
        // acknowledge above the bus top is an error
        dir_rows.push_back(row(iple_pkg::OP_ACK, 0, 0, 15, 0, 0, 31,
                               1, 31, iple_pkg::SRC_NONE, 0, 1));
        // acknowledge at the clock level clears the timer even if idle
        dir_rows.push_back(row(iple_pkg::OP_ACK, 0, 0, 0, 0, 0, 24,
                               1, 24, iple_pkg::SRC_TIMER, 0, 0));
        // acknowledge with nothing to serve
        dir_rows.push_back(row(iple_pkg::OP_ACK, 0, 0, 0, 0, 0, 0,
                               1, 0, iple_pkg::SRC_NONE, 0, 0));
        // bus scan picks the top bus level
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 0, 0, 15, 0, 0, 0,
                               1, 23, iple_pkg::SRC_BUS, 3, 0));
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 0, 0, 1, 0, 0, 0,
                               1, 20, iple_pkg::SRC_BUS, 0, 0));
        // bus level at the ipl ends the scan, software is not reached
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 21, 0, 1, 16'hFFFF, 0, 0,
                               1, 0, iple_pkg::SRC_NONE, 0, 0));
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 0, 0, 0, 16'h8000, 0, 0,
                               1, 15, iple_pkg::SRC_SOFT, 0, 0));
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 14, 0, 0, 16'hFFFF, 0, 0,
                               1, 15, iple_pkg::SRC_SOFT, 0, 0));
        // software at or below the ipl is not granted
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 15, 0, 0, 16'hFFFF, 0, 0,
                               1, 0, iple_pkg::SRC_NONE, 0, 0));
        // software level zero never requests
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 0, 0, 0, 16'h0001, 0, 0,
                               1, 0, iple_pkg::SRC_NONE, 0, 0));
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 0, 0, 0, 16'h0002, 0, 0,
                               1, 1, iple_pkg::SRC_SOFT, 0, 0));
        // post every flag, then serve the console and storage flags in turn
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 0, 0, 0, 0, 31, 0,
                               0, 0, iple_pkg::SRC_NONE, 0, 0));
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 19, 0, 0, 0, 0, 0,
                               0, 0, iple_pkg::SRC_NONE, 0, 0));
        dir_rows.push_back(row(iple_pkg::OP_ACK, 0, 0, 0, 0, 0, 20,
                               0, 0, iple_pkg::SRC_NONE, 0, 0));
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 19, 0, 0, 0, 0, 0,
                               0, 0, iple_pkg::SRC_NONE, 0, 0));
        dir_rows.push_back(row(iple_pkg::OP_ACK, 0, 0, 0, 0, 0, 20,
                               0, 0, iple_pkg::SRC_NONE, 0, 0));
        dir_rows.push_back(row(iple_pkg::OP_ACK, 0, 0, 0, 0, 0, 20,
                               0, 0, iple_pkg::SRC_NONE, 0, 0));
        dir_rows.push_back(row(iple_pkg::OP_ACK, 0, 0, 0, 0, 0, 20,
                               0, 0, iple_pkg::SRC_NONE, 0, 0));
        dir_rows.push_back(row(iple_pkg::OP_ACK, 0, 0, 0, 0, 0, 20,
                               0, 0, iple_pkg::SRC_NONE, 0, 0));
        // acknowledge at a requesting bus level
        dir_rows.push_back(row(iple_pkg::OP_ACK, 0, 0, 1, 0, 0, 20,
                               0, 0, iple_pkg::SRC_NONE, 0, 0));
        dir_rows.push_back(row(iple_pkg::OP_ACK, 0, 0, 4, 0, 0, 22,
                               0, 0, iple_pkg::SRC_NONE, 0, 0));
        // storage only, then full-scale noise
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 19, 0, 0, 0, 8, 0,
                               0, 0, iple_pkg::SRC_NONE, 0, 0));
        dir_rows.push_back(row(iple_pkg::OP_EVAL, 31, 0, 15, 16'hFFFF, 31, 31,
                               0, 0, iple_pkg::SRC_NONE, 0, 0));
        run_rows();
        drain();

        // level settings: extremes, odd ranges, random, back to reset values
        settings.push_back(mk_cfg(0, 0, 0, 0, 0, 0));
        settings.push_back(mk_cfg(31, 31, 31, 31, 31, 31));
        settings.push_back(mk_cfg(5, 30, 26, 17, 12, 9));
        settings.push_back(mk_cfg(31, 3, 0, 31, 10, 10));
        settings.push_back(mk_cfg(0, 21, 18, 22, 18, 18));
        for (p = 0; p < 3; p++)
            settings.push_back(mk_cfg($urandom_range(0, 31), $urandom_range(0, 31),
                                      $urandom_range(0, 20), $urandom_range(10, 31),
                                      $urandom_range(0, 31), $urandom_range(0, 31)));
        settings.push_back(mk_cfg(iple_pkg::HALT_LEVEL_RST, iple_pkg::CLOCK_LEVEL_RST,
                                  iple_pkg::BUS_LOW_LEVEL_RST, iple_pkg::BUS_HIGH_LEVEL_RST,
                                  iple_pkg::CONSOLE_LEVEL_RST,
                                  iple_pkg::STORAGE_LEVEL_RST));

        for (p = 0; p < settings.size(); p++)
        begin
            k = settings[p];
            apply_cfg(k);
            // a few fixed beats against this setting
            dir_rows.push_back(row(iple_pkg::OP_EVAL, 0, 0, 15, 0, 0, 0,
                                   0, 0, iple_pkg::SRC_NONE, 0, 0));
            dir_rows.push_back(row(iple_pkg::OP_EVAL, 0, 0, 8, 16'hFFFF, 1, 0,
                                   0, 0, iple_pkg::SRC_NONE, 0, 0));
            dir_rows.push_back(row(iple_pkg::OP_ACK, 0, 0, 15, 0, 0, k.clock_level,
                                   0, 0, iple_pkg::SRC_NONE, 0, 0));
            dir_rows.push_back(row(iple_pkg::OP_ACK, 0, 0, 15, 0, 0, k.bus_high_level,
                                   0, 0, iple_pkg::SRC_NONE, 0, 0));
            run_rows();
            for (n = 0; n < ITEMS_PER_CFG; n++)
            begin
                it = gen_item();
                send_item(it, 1'b0, none_r);
                pace_sender();
            end
            drain();
        end

        repeat (10) @(posedge clk);
        $display("run covered %0d request beats over %0d level settings, %0d register writes",
                 items_sent, settings.size() + 1, cfg_writes);
        $display("%0d result beats scored, %0d mismatches", results_seen, err_cnt);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
